// File: hw/rtl/btp_pkg.sv
// Shared types, codes and helpers for the binary expression token parser.
package btp_pkg;

   // Parse phases
   localparam logic [2:0] PH_BEFORE_N1 = 3'd0;
   localparam logic [2:0] PH_IN_N1     = 3'd1;
   localparam logic [2:0] PH_BEFORE_OP = 3'd2;
   localparam logic [2:0] PH_BEFORE_N2 = 3'd3;
   localparam logic [2:0] PH_IN_N2     = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ERR_N1 = 2'd1;
   localparam logic [1:0] ST_ERR_OP = 2'd2;
   localparam logic [1:0] ST_ERR_N2 = 2'd3;

   // Operator codes
   localparam logic [1:0] OP_PLUS  = 2'd0;
   localparam logic [1:0] OP_MINUS = 2'd1;
   localparam logic [1:0] OP_TIMES = 2'd2;
   localparam logic [1:0] OP_DIV   = 2'd3;

   // Characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int unsigned NUM_W   = 31;
   localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

   typedef struct packed {
      logic [2:0]       phase;
      logic [NUM_W-1:0] first_value;
      logic [1:0]       operator_held;
      logic [NUM_W-1:0] second_value;
   } btp_state_type;

   typedef struct packed {
      logic [1:0]       parse_status;
      logic [NUM_W-1:0] first_number;
      logic [1:0]       operator_code;
      logic [NUM_W-1:0] second_number;
   } btp_result_type;

   // Multiply by ten and add a digit, saturating at the largest number.
   function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] value,
                                                   input logic [3:0] digit);
      logic [NUM_W+3:0] sum;
      sum = {value, 3'b000} + {2'b00, value, 1'b0} + {{NUM_W{1'b0}}, digit};
      if (sum > {4'b0000, NUM_MAX}) begin
         return NUM_MAX;
      end
      return sum[NUM_W-1:0];
   endfunction

endpackage

// File: hw/rtl/btp_if.sv
// Valid/ready channel interfaces for parser input bytes and parse results.
interface btp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] input_byte;
   logic       end_of_input;

   modport source (output valid, output input_byte, output end_of_input, input ready);
   modport sink   (input valid, input input_byte, input end_of_input, output ready);
endinterface

interface btp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  parse_status;
   logic [30:0] first_number;
   logic [1:0]  operator_code;
   logic [30:0] second_number;

   modport source (output valid, output parse_status, output first_number,
                   output operator_code, output second_number, input ready);
   modport sink   (input valid, input parse_status, input first_number,
                   input operator_code, input second_number, output ready);
endinterface

// File: hw/rtl/binary_expression_token_parser_top.sv
// Top level of the binary expression token parser: input register, step, result register.
//
// Usage:
//   req_bus carries one beat per character (input_byte) or an end-of-input
//   marker (end_of_input = 1). The parser reads "number operator number" with
//   optional space/tab blanks and gives at most one result beat per input beat
//   on rsp_bus: parse_status, the two saturated numbers and operator_code.
//   Error results carry zero numbers and operator.
// Path: an accepted beat waits in the input register, and its result, if any, is
//   registered in the result register that drives rsp_bus.valid; while a result
//   waits on rsp_bus, the next beat is held in the input register.
// Throughput: one input beat per cycle unless rsp_bus stalls; the parse step is a single
//   pass of classify, multiply-by-ten-add and phase update between the two registers.
// Stall: while a result waits on rsp_bus, the step holds the byte in the input
//   register; req_bus.ready stays high only while that register is empty, so
//   one more beat is taken, then req_bus.ready drops until rsp_bus.ready.
// Reset: synchronous, active high; empties both registers and returns the
//   parser to the phase before the first number with cleared values.
module binary_expression_token_parser_top
   import btp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   btp_req_if.sink       req_bus,
   btp_rsp_if.source     rsp_bus
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_eoi_ff;
   btp_state_type  state_ff;
   btp_state_type  state_in;
   btp_result_type result_ff;
   btp_result_type step_result;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           step_emit;
   logic           advance;
   logic           fire;

   // Step the item in the input register when the result slot is free
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign fire    = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   btp_step u_step (
      .cur_state    (state_ff),
      .input_byte   (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .nxt_state    (state_in),
      .emit         (step_emit),
      .result       (step_result)
   );

   // Next valid flags
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire && step_emit) begin
         out_valid_in = 1'b1;
      end
   end

   // Control and parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.phase         <= PH_BEFORE_N1;
         state_ff.first_value   <= '0;
         state_ff.operator_held <= OP_PLUS;
         state_ff.second_value  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         in_byte_ff <= req_bus.input_byte;
         in_eoi_ff  <= req_bus.end_of_input;
      end
      if (fire && step_emit) begin
         result_ff <= step_result;
      end
   end

   // Drive the result channel
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.parse_status  = result_ff.parse_status;
   assign rsp_bus.first_number  = result_ff.first_number;
   assign rsp_bus.operator_code = result_ff.operator_code;
   assign rsp_bus.second_number = result_ff.second_number;

   // Checks
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_IN_N2)
      else $error("parser phase left the legal range");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && step_emit |=> state_ff.phase == PH_BEFORE_N1 && out_valid_ff)
      else $error("result did not restart the parser");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.parse_status != ST_OK |->
         result_ff.first_number == '0 && result_ff.second_number == '0 &&
         result_ff.operator_code == OP_PLUS)
      else $error("error result carries nonzero fields");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eoi_ff))
      else $error("stalled input register changed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(result_ff))
      else $error("pending result was overwritten or dropped");

endmodule

// File: hw/rtl/btp_step.sv
// Single-byte parse step: next parser state and optional result.
module btp_step
   import btp_pkg::*;
(
   input  btp_state_type  cur_state,
   input  logic [7:0]     input_byte,
   input  logic           end_of_input,
   output btp_state_type  nxt_state,
   output logic           emit,
   output btp_result_type result
);

   logic       num_char;
   logic       gap_char;
   logic       is_op;
   logic [1:0] op_code;
   logic [3:0] digit;
   logic [1:0] status;

   // Classify the byte
   always_comb begin
      num_char = input_byte inside {[CH_ZERO:CH_NINE]};
      gap_char = input_byte inside {CH_SPACE, CH_TAB};
      digit    = input_byte[3:0];
      is_op    = 1'b1;
      case (input_byte)
         CH_PLUS:  op_code = OP_PLUS;
         CH_MINUS: op_code = OP_MINUS;
         CH_STAR:  op_code = OP_TIMES;
         CH_SLASH: op_code = OP_DIV;
         default: begin
            op_code = OP_PLUS;
            is_op   = 1'b0;
         end
      endcase
   end

   // Advance the phase
   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      status    = ST_OK;
      case (cur_state.phase)
         PH_IN_N1: begin
            if (end_of_input) begin
               emit   = 1'b1;
               status = ST_ERR_N1;
            end else if (num_char) begin
               nxt_state.first_value = accumulate(cur_state.first_value, digit);
            end else if (gap_char) begin
               nxt_state.phase = PH_BEFORE_OP;
            end else if (is_op) begin
               nxt_state.operator_held = op_code;
               nxt_state.phase         = PH_BEFORE_N2;
            end else begin
               emit   = 1'b1;
               status = ST_ERR_OP;
            end
         end
         PH_BEFORE_OP: begin
            if (end_of_input) begin
               emit   = 1'b1;
               status = ST_ERR_OP;
            end else if (is_op) begin
               nxt_state.operator_held = op_code;
               nxt_state.phase         = PH_BEFORE_N2;
            end else if (!gap_char) begin
               emit   = 1'b1;
               status = ST_ERR_OP;
            end
         end
         PH_BEFORE_N2: begin
            if (end_of_input) begin
               emit   = 1'b1;
               status = ST_ERR_N2;
            end else if (num_char) begin
               nxt_state.second_value = {{(NUM_W-4){1'b0}}, digit};
               nxt_state.phase        = PH_IN_N2;
            end else if (!gap_char) begin
               emit   = 1'b1;
               status = ST_ERR_N2;
            end
         end
         PH_IN_N2: begin
            if (end_of_input) begin
               emit   = 1'b1;
               status = ST_ERR_N2;
            end else if (num_char) begin
               nxt_state.second_value = accumulate(cur_state.second_value, digit);
            end else begin
               emit   = 1'b1;
               status = ST_OK;
            end
         end
         default: begin
            // before the first number, and unused phase codes
            nxt_state.phase = PH_BEFORE_N1;
            if (end_of_input) begin
               emit   = 1'b1;
               status = ST_ERR_N1;
            end else if (num_char) begin
               nxt_state.first_value = {{(NUM_W-4){1'b0}}, digit};
               nxt_state.phase       = PH_IN_N1;
            end else if (!gap_char) begin
               emit   = 1'b1;
               status = ST_ERR_N1;
            end
         end
      endcase

      // Return to start after any result
      if (emit) begin
         nxt_state.phase         = PH_BEFORE_N1;
         nxt_state.first_value   = '0;
         nxt_state.operator_held = OP_PLUS;
         nxt_state.second_value  = '0;
      end
   end

   // Build the result; error results carry zero fields
   always_comb begin
      result.parse_status = status;
      if (status == ST_OK) begin
         result.first_number  = cur_state.first_value;
         result.operator_code = cur_state.operator_held;
         result.second_number = cur_state.second_value;
      end else begin
         result.first_number  = '0;
         result.operator_code = OP_PLUS;
         result.second_number = '0;
      end
   end

endmodule

// File: verif/binary_expression_token_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the binary expression token parser: directed and random byte streams checked in order.
module binary_expression_token_parser_top_tb
   import btp_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned beats_sent = 0;
   int unsigned failures = 0;

   // Parse results still owed by the block, oldest first
   btp_result_type results_due[$];
   btp_result_type oldest_due;

   // Predicted parser state
   logic [2:0]       cur_phase;
   logic [NUM_W-1:0] lhs_value;
   logic [1:0]       held_op;
   logic [NUM_W-1:0] rhs_value;

   btp_req_if req_bus();
   btp_rsp_if rsp_bus();

   binary_expression_token_parser_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic logic char_is_num(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic logic char_is_gap(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
   endfunction

   // Return {found, operator code}
   function automatic logic [2:0] decode_operator(input logic [7:0] b);
      case (b)
         CH_PLUS:  return {1'b1, OP_PLUS};
         CH_MINUS: return {1'b1, OP_MINUS};
         CH_STAR:  return {1'b1, OP_TIMES};
         CH_SLASH: return {1'b1, OP_DIV};
         default:  return 3'b000;
      endcase
   endfunction

   // Shift in one decimal digit, clamp at the largest number
   function automatic logic [NUM_W-1:0] times_ten_plus(input logic [NUM_W-1:0] value,
                                                       input logic [7:0] b);
      logic [63:0] wide;
      logic [7:0]  digit;
      digit = b - CH_ZERO;
      wide = 64'(value) * 64'd10 + 64'(digit);
      if (wide > 64'(NUM_MAX)) begin
         return NUM_MAX;
      end
      return wide[NUM_W-1:0];
   endfunction

   task automatic clear_parser();
      cur_phase = PH_BEFORE_N1;
      lhs_value = '0;
      held_op   = OP_PLUS;
      rhs_value = '0;
   endtask

   // Queue one result; error results carry zero fields
   task automatic finish_parse(input logic [1:0] status);
      btp_result_type r;
      r = '0;
      r.parse_status = status;
      if (status == ST_OK) begin
         r.first_number  = lhs_value;
         r.operator_code = held_op;
         r.second_number = rhs_value;
      end
      results_due.push_back(r);
      clear_parser();
   endtask

   // Advance the predicted parser by one accepted beat
   task automatic advance_parser(input logic [7:0] b, input logic eoi);
      logic [2:0] op;
      logic [2:0] ph;
      op = decode_operator(b);
      ph = (cur_phase > PH_IN_N2) ? PH_BEFORE_N1 : cur_phase;
      case (ph)
         PH_IN_N1: begin
            if (eoi) begin
               finish_parse(ST_ERR_N1);
            end else if (char_is_num(b)) begin
               lhs_value = times_ten_plus(lhs_value, b);
            end else if (char_is_gap(b)) begin
               cur_phase = PH_BEFORE_OP;
            end else if (op[2]) begin
               held_op = op[1:0];
               cur_phase = PH_BEFORE_N2;
            end else begin
               finish_parse(ST_ERR_OP);
            end
         end
         PH_BEFORE_OP: begin
            if (eoi) begin
               finish_parse(ST_ERR_OP);
            end else if (op[2]) begin
               held_op = op[1:0];
               cur_phase = PH_BEFORE_N2;
            end else if (!char_is_gap(b)) begin
               finish_parse(ST_ERR_OP);
            end
         end
         PH_BEFORE_N2: begin
            if (eoi) begin
               finish_parse(ST_ERR_N2);
            end else if (char_is_num(b)) begin
               rhs_value = NUM_W'(b - CH_ZERO);
               cur_phase = PH_IN_N2;
            end else if (!char_is_gap(b)) begin
               finish_parse(ST_ERR_N2);
            end
         end
         PH_IN_N2: begin
            if (eoi) begin
               finish_parse(ST_ERR_N2);
            end else if (char_is_num(b)) begin
               rhs_value = times_ten_plus(rhs_value, b);
            end else begin
               finish_parse(ST_OK);
            end
         end
         default: begin
            cur_phase = PH_BEFORE_N1;
            if (eoi) begin
               finish_parse(ST_ERR_N1);
            end else if (char_is_num(b)) begin
               lhs_value = NUM_W'(b - CH_ZERO);
               cur_phase = PH_IN_N1;
            end else if (!char_is_gap(b)) begin
               finish_parse(ST_ERR_N1);
            end
         end
      endcase
   endtask

   // Drive one beat from a falling edge, hold until accepted, return at a falling edge
   task automatic send_beat(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.input_byte   <= b;
      req_bus.end_of_input <= eoi;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      advance_parser(b, eoi);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) begin
         send_beat(s[i], 1'b0);
      end
   endtask

   task automatic send_end();
      send_beat(8'($urandom), 1'b1);
   endtask

   task automatic add_blanks(ref logic [8:0] seq[$]);
      repeat ($urandom_range(2)) begin
         seq.push_back({1'b0, ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB});
      end
   endtask

   // Mostly short numbers, now and then long enough to saturate
   task automatic add_number(ref logic [8:0] seq[$]);
      int unsigned ndig;
      ndig = ($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
      repeat (ndig) begin
         seq.push_back({1'b0, CH_ZERO + 8'($urandom_range(9))});
      end
   endtask

   // The special cases below, once each, no idling
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // tab and space blanks, zero, operator after a blank, blank terminator
      send_text("0\t* 9 ");
      // operator right after the first number, top byte as terminator
      send_text("5/7");
      send_beat(8'hFF, 1'b0);
      // bad byte and end of input before the first number
      send_beat(8'h00, 1'b0);
      send_end();
      // end of input inside the first number
      send_text("3");
      send_end();
      // bad byte ending the first number
      send_text("8a");
      // end of input where the operator is expected
      send_text("4 ");
      send_end();
      // end of input and bad byte before the second number
      send_text("6-");
      send_end();
      send_text("2+x");
      // end of input inside the second number
      send_text("1-5");
      send_end();
   endtask

   // Mostly well-formed expressions with random content, some broken, some noise
   task automatic test_random_expressions(input int unsigned beats,
                                          input int unsigned idle_pct,
                                          input int unsigned stall_pct);
      logic [8:0]  seq[$];
      logic [7:0]  term;
      int unsigned target;
      int unsigned cut;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = beats_sent + beats;
      while (beats_sent < target) begin
         seq.delete();
         if ($urandom_range(9) == 0) begin
            seq.push_back({1'($urandom_range(5) == 0), 8'($urandom)});
         end else begin
            add_blanks(seq);
            add_number(seq);
            add_blanks(seq);
            case ($urandom_range(3))
               0: seq.push_back({1'b0, CH_PLUS});
               1: seq.push_back({1'b0, CH_MINUS});
               2: seq.push_back({1'b0, CH_STAR});
               default: seq.push_back({1'b0, CH_SLASH});
            endcase
            add_blanks(seq);
            add_number(seq);
            if ($urandom_range(9) == 0) begin
               seq.push_back({1'b1, 8'($urandom)});
            end else begin
               do begin
                  term = 8'($urandom);
               end while (char_is_num(term));
               seq.push_back({1'b0, term});
            end
            // break the sequence somewhere and finish it with a random beat
            if ($urandom_range(4) == 0) begin
               cut = $urandom_range(seq.size() - 1);
               while (seq.size() > cut) begin
                  void'(seq.pop_back());
               end
               seq.push_back({1'($urandom_range(3) == 0), 8'($urandom)});
            end
         end
         foreach (seq[i]) begin
            send_beat(seq[i][7:0], seq[i][8]);
         end
      end
   endtask

   // Random receiver stalls, driven at the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [NUM_W-1:0] want,
                              input logic [NUM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Compare each result beat with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d %0d op %0d %0d",
                     $time, rsp_bus.parse_status, rsp_bus.first_number,
                     rsp_bus.operator_code, rsp_bus.second_number);
            failures++;
         end else begin
            oldest_due = results_due.pop_front();
            check_field("parse_status", NUM_W'(oldest_due.parse_status),
                        NUM_W'(rsp_bus.parse_status));
            check_field("first_number", oldest_due.first_number, rsp_bus.first_number);
            check_field("operator_code", NUM_W'(oldest_due.operator_code),
                        NUM_W'(rsp_bus.operator_code));
            check_field("second_number", oldest_due.second_number, rsp_bus.second_number);
         end
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.input_byte   = 8'h00;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      clear_parser();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_expressions(100, 0, 0);
      test_random_expressions(100, 87, 0);
      test_random_expressions(100, 0, 87);
      test_random_expressions(100, 9, 9);

      // Drain: stop sending, open the receiver, let late beats show up
      req_bus.valid <= 1'b0;
      recv_stall_pct = 0;
      while (results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/btp_pkg.sv
hw/rtl/btp_if.sv
hw/rtl/btp_step.sv
hw/rtl/binary_expression_token_parser_top.sv
verif/binary_expression_token_parser_top_tb.sv
